// File: rtl/irt_pkg.sv
// Package for the interval range table: widths, codes and transaction types.
// No dependencies.
`timescale 1ns / 1ps
package irt_pkg;
  localparam int MaxEntries = 32;
  localparam int KeyBits = 16;
  localparam int ValueBits = 8;
  localparam int IdxBits = $clog2(MaxEntries);
  localparam int CntBits = $clog2(MaxEntries + 1);

  localparam logic CMD_ASSIGN = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic command;
    logic signed [KeyBits-1:0] range_begin;
    logic signed [KeyBits-1:0] range_end;
    logic [ValueBits-1:0] new_value;
    logic signed [KeyBits-1:0] probe_key;
  } in_item_t;

  typedef struct packed {
    logic [ValueBits-1:0] found_value;
    logic [1:0] status;
    logic [5:0] entries_used;
  } out_item_t;

  typedef struct packed {
    logic [KeyBits-1:0] key;
    logic [ValueBits-1:0] value;
  } entry_t;
endpackage

// File: rtl/irt_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module irt_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/interval_range_table_core.sv
// Interval range table: an interval map held as sorted breakpoints in two RAM banks.
// Depends on irt_pkg and irt_ram.
`timescale 1ns / 1ps
// The table maps every signed key to a value. Breakpoints are kept sorted in two
// ping-pong RAMs; a transaction streams the active bank through a single read
// port, and an assign that rebuilds the table writes it to the other bank, at most
// one entry per cycle. The block takes one transaction at a time. An empty
// interval goes straight to its result; a lookup or any other assign first runs a
// counting pass over the active bank, and an assign that rebuilds the table then
// adds a copy pass. The result waits in an output register, and the next
// transaction is accepted no earlier than the cycle after the result is taken.
// There is no clearing pass after reset.
module interval_range_table_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [irt_pkg::ValueBits-1:0]        cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  irt_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output irt_pkg::out_item_t                   out_data
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_COPY = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;

  localparam int IB = irt_pkg::IdxBits;
  localparam int CB = irt_pkg::CntBits;
  localparam int KB = irt_pkg::KeyBits;
  localparam int VB = irt_pkg::ValueBits;
  localparam int EB = KB + VB;

  logic [2:0] state;
  logic [VB-1:0] default_value;
  logic [CB-1:0] entry_count;
  logic bank;
  irt_pkg::in_item_t cur;
  logic [CB-1:0] rd_idx;
  logic rd_vld;
  logic [CB-1:0] rd_pos;
  logic [VB-1:0] prev_val;
  logic [VB-1:0] end_val;
  logic [VB-1:0] at_end_val;
  logic has_at_end;
  logic [CB:0] new_cnt;
  logic [CB:0] wr_n;
  logic did_begin;
  logic did_end;
  logic [CB-1:0] pass_cnt;
  irt_pkg::out_item_t result;

  logic [KB-1:0] ob;
  logic [KB-1:0] oe;
  logic [KB-1:0] op;
  logic [KB-1:0] rk;
  logic [VB-1:0] rv;
  irt_pkg::entry_t rd0;
  irt_pkg::entry_t rd1;
  irt_pkg::entry_t rd_e;
  logic we0;
  logic we1;
  logic [IB-1:0] waddr;
  irt_pkg::entry_t wdata;
  logic [IB-1:0] raddr;
  logic wr_en;

  assign ob = cur.range_begin ^ {1'b1, {(KB-1){1'b0}}};
  assign oe = cur.range_end ^ {1'b1, {(KB-1){1'b0}}};
  assign op = cur.probe_key ^ {1'b1, {(KB-1){1'b0}}};
  assign rd_e = bank ? rd1 : rd0;
  assign rk = rd_e.key ^ {1'b1, {(KB-1){1'b0}}};
  assign rv = rd_e.value;
  assign we0 = wr_en && bank;
  assign we1 = wr_en && !bank;

  irt_ram #(.Width(EB), .Depth(irt_pkg::MaxEntries)) u_bank0 (
    .clk(clk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd0)
  );
  irt_ram #(.Width(EB), .Depth(irt_pkg::MaxEntries)) u_bank1 (
    .clk(clk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd1)
  );

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data = result;

  // Copy pass emission: entries are written in sorted order with begin/end inserts.
  logic emit_en;
  irt_pkg::entry_t emit_e;
  logic take_rd;
  logic emit_end_first;
  logic pass_done;
  logic prime;
  logic hold_rd;
  logic [CB-1:0] hold_idx;

  assign prime = (state == S_COPY) && (pass_cnt == '1) && !rd_vld && (rd_idx == '0)
                 && (entry_count != '0) && (wr_n == '0) && !did_begin;

  always_comb begin
    emit_en = 1'b0;
    emit_e = '0;
    take_rd = 1'b0;
    emit_end_first = 1'b0;
    pass_done = 1'b0;
    if (state == S_COPY && pass_cnt != 0 && !prime) begin
      if (rd_vld && rk < ob) begin
        emit_en = 1'b1;
        emit_e.key = rd_e.key;
        emit_e.value = rv;
        take_rd = 1'b1;
      end else if (!did_begin) begin
        emit_en = (prev_val != cur.new_value);
        emit_e.key = cur.range_begin;
        emit_e.value = cur.new_value;
      end else if (rd_vld && rk < oe) begin
        take_rd = 1'b1;
      end else if (!did_end) begin
        emit_end_first = 1'b1;
        emit_e.key = cur.range_end;
        if (has_at_end) begin
          emit_en = (at_end_val != cur.new_value);
          emit_e.value = at_end_val;
          take_rd = 1'b1;
        end else begin
          emit_en = (end_val != cur.new_value);
          emit_e.value = end_val;
        end
      end else if (rd_vld) begin
        emit_en = 1'b1;
        emit_e = rd_e;
        take_rd = 1'b1;
      end else begin
        pass_done = 1'b1;
      end
    end
  end

  // A held entry is read again so the RAM output stays on it.
  assign hold_rd = (state == S_COPY) && rd_vld && !take_rd;
  assign hold_idx = rd_idx - 1'b1;
  assign raddr = hold_rd ? hold_idx[IB-1:0] : rd_idx[IB-1:0];

  assign wr_en = emit_en;
  assign waddr = wr_n[IB-1:0];
  assign wdata = emit_e;

  // Counting-pass view of the current read entry.
  logic scan_vld;
  assign scan_vld = (state == S_SCAN) && rd_vld;

  logic [CB:0] scan_add;
  always_comb begin
    scan_add = '0;
    if (scan_vld && (rk < ob || rk > oe)) begin
      scan_add = {{CB{1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      default_value <= '0;
      entry_count <= '0;
      bank <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      if (cfg_we) begin
        default_value <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur <= in_data;
            rd_idx <= '0;
            rd_pos <= '0;
            rd_vld <= 1'b0;
            prev_val <= default_value;
            end_val <= default_value;
            has_at_end <= 1'b0;
            new_cnt <= '0;
            wr_n <= '0;
            did_begin <= 1'b0;
            did_end <= 1'b0;
            pass_cnt <= '0;
            if (in_data.command == irt_pkg::CMD_ASSIGN &&
                in_data.range_begin >= in_data.range_end) begin
              result <= '{found_value: '0, status: irt_pkg::ST_EMPTY,
                          entries_used: 6'(entry_count)};
              state <= S_OUT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Issue reads for entries 0..count-1; the registered read data arrives in the next cycle.
          if (rd_idx < entry_count) begin
            rd_idx <= rd_idx + 1'b1;
            rd_vld <= 1'b1;
          end else begin
            rd_vld <= 1'b0;
          end
          rd_pos <= rd_idx;
          if (scan_vld) begin
            new_cnt <= new_cnt + scan_add;
            if ((cur.command == irt_pkg::CMD_LOOKUP) ? (rk <= op) : (rk < ob)) begin
              prev_val <= rv;
            end
            if (rk <= oe) end_val <= rv;
            if (rk == oe) begin
              has_at_end <= 1'b1;
              at_end_val <= rv;
            end
          end
          if (!rd_vld && rd_idx == entry_count && rd_pos == entry_count) begin
            if (cur.command == irt_pkg::CMD_LOOKUP) begin
              result <= '{found_value: prev_val, status: irt_pkg::ST_DONE,
                          entries_used: 6'(entry_count)};
              state <= S_OUT;
            end else begin
              logic [CB:0] total;
              total = new_cnt + {{CB{1'b0}}, (prev_val != cur.new_value)}
                    + {{CB{1'b0}}, (has_at_end ? (at_end_val != cur.new_value)
                                               : (end_val != cur.new_value))};
              if (total > (CB+1)'(irt_pkg::MaxEntries)) begin
                result <= '{found_value: '0, status: irt_pkg::ST_FULL,
                            entries_used: 6'(entry_count)};
                state <= S_OUT;
              end else begin
                new_cnt <= total;
                rd_idx <= '0;
                pass_cnt <= '1;
                state <= S_COPY;
              end
            end
          end
        end
        S_COPY: begin
          if (prime) begin
            // Prime the first read.
            rd_idx <= {{(CB-1){1'b0}}, 1'b1};
            rd_vld <= 1'b1;
            pass_cnt <= pass_cnt - 1'b1;
          end else begin
            if (emit_en) wr_n <= wr_n + 1'b1;
            if (!did_begin && !(rd_vld && rk < ob)) did_begin <= 1'b1;
            if (emit_end_first) did_end <= 1'b1;
            if (take_rd) begin
              if (rd_idx < entry_count) begin
                rd_idx <= rd_idx + 1'b1;
                rd_vld <= 1'b1;
              end else begin
                rd_vld <= 1'b0;
              end
            end
            if (pass_cnt == '1) pass_cnt <= pass_cnt - 1'b1;
            if (pass_done) begin
              entry_count <= new_cnt[CB-1:0];
              bank <= !bank;
              result <= '{found_value: '0, status: irt_pkg::ST_DONE,
                          entries_used: 6'(new_cnt)};
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CB'(irt_pkg::MaxEntries)) else $error("entry count overflow");
  a_bank_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (bank != $past(bank)) |-> (state == S_OUT && result.status == irt_pkg::ST_DONE))
    else $error("bank swapped without a completed assign");
  a_write_bound: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_n < (CB+1)'(irt_pkg::MaxEntries))) else $error("write past table");
`endif
endmodule
